FILE: rtl/lrcf_pkg.sv
// shared types, constants and the crc step function for the lrc/crc packet framer
package lrcf_pkg;

   localparam logic [15:0] CrcInit       = 16'hFFFF;
   localparam logic [15:0] CrcPoly       = 16'h1021;
   localparam logic [7:0]  WantedIdReset = 8'd20;
   localparam logic [2:0]  WindowFull    = 3'd4;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   // register index is the word address bit
   localparam logic        CsrIdxWantedId = 1'b0;

   typedef struct packed {
      logic [7:0] packet_id;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic       payload_valid;
      logic       last;
      logic       crc_ok;
      logic       id_match;
   } result_type;

   // crc-16/ccitt-false, one byte, msb first
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/lrcf_deframe.sv
// header hunt, payload pass-through and running crc for one accepted byte per cycle
module lrcf_deframe
   import lrcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       beat_accept,
   input  logic [7:0] rx_byte,
   input  logic [7:0] wanted_id,
   output logic       res_valid,
   output result_type res
);

   logic [31:0] window_ff, window_in;
   logic [2:0]  fill_ff, fill_in;
   logic        in_packet_ff, in_packet_in;
   logic [7:0]  cur_id_ff, cur_id_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] exp_crc_ff, exp_crc_in;

   logic [15:0] crc_next;
   logic [8:0]  count_plus;
   logic        fin;
   logic [9:0]  hdr_sum;
   logic [7:0]  lrc_calc;
   logic        hdr_hit;

   assign crc_next   = crc_update(crc_ff, rx_byte);
   assign count_plus = {1'b0, count_ff} + 9'd1;
   assign fin        = count_plus >= {1'b0, len_ff};
   assign hdr_sum    = {2'b00, window_ff[23:16]} + {2'b00, window_ff[15:8]}
                     + {2'b00, window_ff[7:0]} + {2'b00, rx_byte};
   // two's complement lrc of id, length and both crc bytes
   assign lrc_calc   = (~hdr_sum[7:0]) + 8'd1;
   assign hdr_hit    = (fill_ff >= WindowFull) && (lrc_calc == window_ff[31:24]);

   always_comb begin
      window_in    = window_ff;
      fill_in      = fill_ff;
      in_packet_in = in_packet_ff;
      cur_id_in    = cur_id_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      exp_crc_in   = exp_crc_ff;
      res_valid    = 1'b0;
      res          = '0;
      res.packet_id = cur_id_ff;

      if (beat_accept) begin
         if (in_packet_ff) begin
            crc_in             = crc_next;
            count_in           = count_plus[7:0];
            res_valid          = 1'b1;
            res.packet_id      = cur_id_ff;
            res.data_byte      = rx_byte;
            res.byte_index     = count_ff;
            res.payload_valid  = 1'b1;
            res.last           = fin;
            res.crc_ok         = fin && (crc_next == exp_crc_ff);
            res.id_match       = cur_id_ff == wanted_id;
            if (fin) begin
               in_packet_in = 1'b0;
               fill_in      = '0;
               window_in    = '0;
            end
         end else if (hdr_hit) begin
            cur_id_in  = window_ff[23:16];
            len_in     = window_ff[15:8];
            count_in   = '0;
            crc_in     = CrcInit;
            exp_crc_in = {rx_byte, window_ff[7:0]};
            window_in  = '0;
            fill_in    = '0;
            if (window_ff[15:8] == 8'd0) begin
               // empty packet closes at once
               res_valid     = 1'b1;
               res.packet_id = window_ff[23:16];
               res.last      = 1'b1;
               res.crc_ok    = {rx_byte, window_ff[7:0]} == CrcInit;
               res.id_match  = window_ff[23:16] == wanted_id;
            end else begin
               in_packet_in = 1'b1;
            end
         end else begin
            window_in = {window_ff[23:0], rx_byte};
            fill_in   = (fill_ff >= WindowFull) ? WindowFull : fill_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         fill_ff      <= '0;
         in_packet_ff <= 1'b0;
         cur_id_ff    <= '0;
         len_ff       <= '0;
         count_ff     <= '0;
         crc_ff       <= CrcInit;
         exp_crc_ff   <= '0;
      end else begin
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         in_packet_ff <= in_packet_in;
         cur_id_ff    <= cur_id_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         exp_crc_ff   <= exp_crc_in;
      end
   end

   a_res_needs_beat: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> beat_accept) else $error("result without accepted beat");
   a_last_ends_packet: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.last |=> !in_packet_ff && fill_ff == 3'd0)
      else $error("packet did not close on last");
   a_crc_ok_only_last: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.last |-> !res.crc_ok) else $error("crc_ok off last");
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WindowFull) else $error("window fill overflow");
   a_count_below_len: assert property (@(posedge clock) disable iff (reset)
      in_packet_ff |-> count_ff < len_ff) else $error("payload count past length");

endmodule

FILE: rtl/lrcf_out_buf.sv
// result register with a skid stage that absorbs one more result under output stall
module lrcf_out_buf
   import lrcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   input  result_type res,
   output logic       full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       main_free;

   assign main_free = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = res_valid;
            skid_in       = res;
         end else begin
            main_valid_in = res_valid;
            main_in       = res;
         end
      end else if (res_valid) begin
         // skid is empty here, the input was not stalled
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff) else $error("skid holds data ahead of main");
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_stall |-> !res_valid) else $error("result lost in full buffer");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_stall |=> main_valid_ff) else $error("skid beat dropped");

endmodule

FILE: rtl/lrc_crc_packet_framer.sv
// top level of the lrc/crc packet framer: csr port, deframer and result buffer
// One received byte is taken per beat: the header check, payload crc step and result
// formatting sit between the framer state registers and the result register, so bytes
// stream in back to back at one per clock while req_stall is low.
// Results are registered in the result buffer before they reach rsp; this two-entry buffer
// absorbs output stall, and req_stall rises only once both entries are occupied.
// Headers are hunted over a sliding five-byte window; a zero-length packet gives a
// single end result with payload_valid low. Write wanted_id only while the block is idle.
module lrc_crc_packet_framer
   import lrcf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_packet_id,
   output logic [7:0]              rsp_data_byte,
   output logic [7:0]              rsp_byte_index,
   output logic                    rsp_payload_valid,
   output logic                    rsp_last,
   output logic                    rsp_crc_ok,
   output logic                    rsp_id_match,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic [7:0] wanted_id_ff, wanted_id_in;
   logic       csr_wr;
   logic       beat_accept;
   logic       res_valid;
   result_type res;
   result_type out_data;
   logic       buf_full;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      wanted_id_in = wanted_id_ff;
      if (csr_wr && csr_paddr[2] == CsrIdxWantedId) begin
         wanted_id_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_id_ff <= WantedIdReset;
      end else begin
         wanted_id_ff <= wanted_id_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CsrIdxWantedId: csr_prdata = {{(CsrDataWidth-8){1'b0}}, wanted_id_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign req_stall   = buf_full;
   assign beat_accept = req_valid && !req_stall;

   lrcf_deframe u_deframe (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .rx_byte     (req_rx_byte),
      .wanted_id   (wanted_id_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   lrcf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_packet_id     = out_data.packet_id;
   assign rsp_data_byte     = out_data.data_byte;
   assign rsp_byte_index    = out_data.byte_index;
   assign rsp_payload_valid = out_data.payload_valid;
   assign rsp_last          = out_data.last;
   assign rsp_crc_ok        = out_data.crc_ok;
   assign rsp_id_match      = out_data.id_match;

endmodule
